### rtl/core/rtti_pkg.sv
package rtti_pkg;

    // payload of one input transaction
    typedef struct packed {
        logic [7:0] character;
        logic       has_char;
        logic       last;
    } t_in_item;

    // payload of one result transaction
    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [7:0]  consumed;
    } t_out_item;

    // result status codes
    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusNoDigit = 2'd1;
    localparam logic [1:0] StatusRange   = 2'd2;

    // configuration register indexes
    localparam int         CfgIndexBits = 1;
    localparam int         CfgDataBits  = 5;
    localparam logic [0:0] CfgRadix     = 1'd0;
    localparam logic [0:0] CfgSigned    = 1'd1;

    // radix limits and reset value
    localparam logic [4:0] RadixMin   = 5'd2;
    localparam logic [4:0] RadixMax   = 5'd16;
    localparam logic [4:0] RadixReset = 5'd16;

    // character codes
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowF  = 8'h66;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpF   = 8'h46;
    localparam logic [4:0] NoDigit   = 5'h10;

    // digit value of a character, NoDigit when it is none
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = NoDigit;
        if (c >= CharZero && c <= CharNine) begin
            d = 5'(c - CharZero);
        end else if (c >= CharLowA && c <= CharLowF) begin
            d = 5'(c - CharLowA) + 5'd10;
        end else if (c >= CharUpA && c <= CharUpF) begin
            d = 5'(c - CharUpA) + 5'd10;
        end
        return d;
    endfunction

endpackage

### rtl/core/radix_text_to_integer_parser.sv
// Radix text-to-integer parser.
// Input channel: one character of a token per transaction (i_in_valid,
// o_in_stall, i_in_data); the transaction with last set closes the token.
// An empty token is a single last transaction with has_char clear.
// Output channel: one result per token (o_out_valid, i_out_stall,
// o_out_data) holding value, status and consumed count.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_index
// (0 radix, 1 signed mode); write only while no token is in flight.
// Throughput: one character per cycle while the input does not stall, set by
// the combinational multiply-accumulate and range check that carries the
// accumulator from one character to the next. A closing transaction passes
// through the input stage and then the result register to the output.
// Reset (synchronous, active low) empties both stages, clears the token
// state and sets radix 16, unsigned mode.
// When the receiver stalls, the held result stays put and characters keep
// flowing into the token state; the input only stalls once a closing
// transaction sits in the input stage and finds the result register occupied.
module radix_text_to_integer_parser #(
    parameter int CHAR_BITS  = 8,
    parameter int VALUE_BITS = 64,
    parameter int MAX_COUNT  = 255
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  rtti_pkg::t_in_item       i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output rtti_pkg::t_out_item      o_out_data,
    input  logic                     i_cfg_we,
    input  logic [rtti_pkg::CfgIndexBits-1:0] i_cfg_index,
    input  logic [rtti_pkg::CfgDataBits-1:0]  i_cfg_data
);
    import rtti_pkg::*;

    localparam logic [7:0] CharMask   = (CHAR_BITS >= 8) ? 8'hFF
                                        : 8'((1 << CHAR_BITS) - 1);
    localparam logic [7:0] CountLimit = (MAX_COUNT < 255) ? 8'(MAX_COUNT) : 8'd255;

    // parse phases
    localparam logic [1:0] PhSign    = 2'd0;
    localparam logic [1:0] PhZeros   = 2'd1;
    localparam logic [1:0] PhDigits  = 2'd2;
    localparam logic [1:0] PhStopped = 2'd3;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic [4:0]            r_radix;
    logic                  r_signed_mode;

    logic [VALUE_BITS-1:0] r_acc,   n_acc;
    logic [1:0]            r_phase, n_phase;
    logic                  r_neg,   n_neg;
    logic [7:0]            r_cnt,   n_cnt;
    logic                  r_err,   n_err;
    logic                  r_seen,  n_seen;

    logic                  out_free;
    logic                  fire;
    logic [7:0]            chr;
    logic [4:0]            radix_eff;
    logic [VALUE_BITS-1:0] mac_acc;
    logic                  digit_ok;
    logic                  overflow;
    logic                  take;
    logic [VALUE_BITS-1:0] signed_val;
    t_out_item             result;

    // flow control between the two stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall = r_in_valid && !fire;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix       <= RadixReset;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgRadix:  r_radix       <= i_cfg_data;
                CfgSigned: r_signed_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective radix and character
    always_comb begin
        if (r_radix < RadixMin) begin
            radix_eff = RadixMin;
        end else if (r_radix > RadixMax) begin
            radix_eff = RadixMax;
        end else begin
            radix_eff = r_radix;
        end
    end
    assign chr = r_in.character & CharMask;

    rtti_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .i_acc         (r_acc),
        .i_char        (chr),
        .i_radix       (radix_eff),
        .i_signed_mode (r_signed_mode),
        .i_negative    (r_neg),
        .o_acc         (mac_acc),
        .o_digit_ok    (digit_ok),
        .o_overflow    (overflow)
    );

    // token state update for one character
    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_err   = r_err;
        n_seen  = r_seen;
        take    = r_in.has_char;
        if (take && n_phase == PhSign) begin
            n_phase = PhZeros;
            if (r_signed_mode && chr == CharMinus) begin
                n_neg = 1'b1;
                if (n_cnt < CountLimit) n_cnt = n_cnt + 8'd1;
                take = 1'b0;
            end
        end
        if (take && n_phase == PhZeros) begin
            if (chr == CharZero) begin
                n_seen = 1'b1;
                if (n_cnt < CountLimit) n_cnt = n_cnt + 8'd1;
                take = 1'b0;
            end else begin
                n_phase = PhDigits;
            end
        end
        if (take && n_phase == PhDigits) begin
            if (!digit_ok) begin
                n_phase = PhStopped;
            end else if (overflow) begin
                n_err   = 1'b1;
                n_phase = PhStopped;
            end else begin
                n_acc  = mac_acc;
                n_seen = 1'b1;
                if (n_cnt < CountLimit) n_cnt = n_cnt + 8'd1;
            end
        end
    end

    // result of a closing transaction
    assign signed_val = n_neg ? (~n_acc + 1'b1) : n_acc;
    always_comb begin
        if (n_err) begin
            result.value    = '0;
            result.status   = StatusRange;
            result.consumed = n_cnt;
        end else if (!n_seen) begin
            result.value    = '0;
            result.status   = StatusNoDigit;
            result.consumed = '0;
        end else begin
            result.value    = 64'(signed_val);
            result.status   = StatusOk;
            result.consumed = n_cnt;
        end
    end

    // token state registers, cleared after every closing transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in.last)) begin
            r_acc   <= '0;
            r_phase <= PhSign;
            r_neg   <= 1'b0;
            r_cnt   <= '0;
            r_err   <= 1'b0;
            r_seen  <= 1'b0;
        end else if (fire) begin
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_seen  <= n_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire && r_in.last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/rtti_accum.sv
module rtti_accum #(
    parameter int VALUE_BITS = 64
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic [7:0]            i_char,
    input  logic [4:0]            i_radix,
    input  logic                  i_signed_mode,
    input  logic                  i_negative,
    output logic [VALUE_BITS-1:0] o_acc,
    output logic                  o_digit_ok,
    output logic                  o_overflow
);
    import rtti_pkg::*;

    localparam int ProdBits = VALUE_BITS + 6;

    logic [4:0]            digit;
    logic [ProdBits-1:0]   sum;
    logic [VALUE_BITS-1:0] limit;
    logic [VALUE_BITS-1:0] half;

    // digit decode and acceptance against the radix
    assign digit      = digit_of(i_char);
    assign o_digit_ok = (digit < i_radix);

    // multiply-accumulate, kept wide enough for an exact range check
    assign sum   = ProdBits'(i_acc) * ProdBits'(i_radix) + ProdBits'(digit);
    assign o_acc = sum[VALUE_BITS-1:0];

    // magnitude limit for the current sign and mode
    assign half = {1'b1, {(VALUE_BITS-1){1'b0}}};
    always_comb begin
        if (i_signed_mode || i_negative) begin
            limit = i_negative ? half : half - 1'b1;
        end else begin
            limit = '1;
        end
    end

    assign o_overflow = (sum > ProdBits'(limit));

endmodule
